FILE: src/mtsag_pkg.sv
// Shared constants and codes for the multi-tensor strided address generator.
// No dependencies; the interfaces and the core refer to this package.
`timescale 1ns / 1ps

package mtsag_pkg;

  // Table dimensions.
  localparam int MAX_DIMS    = 8;
  localparam int MAX_TENSORS = 8;

  // Index and count widths derived from the table dimensions.
  localparam int DIM_IW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TEN_IW  = (MAX_TENSORS > 1) ? $clog2(MAX_TENSORS) : 1;
  localparam int DCNT_W  = $clog2(MAX_DIMS + 1);
  localparam int TCNT_W  = $clog2(MAX_TENSORS + 1);
  localparam int TAB_AW  = TEN_IW + DIM_IW;
  localparam int TAB_DEPTH = 1 << TAB_AW;

  // Field widths of the words on the channels.
  localparam int MODE_W = 3;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STEP_W = 16;
  localparam int EXT_W  = 16;
  localparam int CFG_W  = 4;

  // Configuration port widths.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD_EXTENT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_STRIDE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT_OUTER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADVANCE     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BACK_UP     = 3'd4;

  // Configuration register indexes.
  localparam logic REG_DIM_COUNT    = 1'b0;
  localparam logic REG_TENSOR_COUNT = 1'b1;

endpackage

FILE: src/mtsag_in_if.sv
// Input channel of the address generator: valid/ready handshake and item fields.
// Depends on mtsag_pkg for field widths.
`timescale 1ns / 1ps

interface mtsag_in_if;
  logic                                valid;
  logic                                ready;
  logic [mtsag_pkg::MODE_W-1:0]        mode;
  logic [mtsag_pkg::IDX_W-1:0]         dim_index;
  logic [mtsag_pkg::IDX_W-1:0]         tensor_index;
  logic signed [mtsag_pkg::VAL_W-1:0]  load_value;
  logic [mtsag_pkg::STEP_W-1:0]        step_count;

  modport source (output valid, mode, dim_index, tensor_index, load_value, step_count,
                  input ready);
  modport sink   (input valid, mode, dim_index, tensor_index, load_value, step_count,
                  output ready);
endinterface

FILE: src/mtsag_out_if.sv
// Result channel of the address generator: valid/ready handshake and offset fields.
// Depends on mtsag_pkg for field widths.
`timescale 1ns / 1ps

interface mtsag_out_if;
  logic                                valid;
  logic                                ready;
  logic [mtsag_pkg::IDX_W-1:0]         which_tensor;
  logic signed [mtsag_pkg::VAL_W-1:0]  offset;
  logic                                last;

  modport source (output valid, which_tensor, offset, last, input ready);
  modport sink   (input valid, which_tensor, offset, last, output ready);
endinterface

FILE: src/mtsag_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mtsag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/multi_tensor_strided_address_generator_core.sv
// An extent load is written when accepted; a stride load goes accept, multiply, write.
// A movement sweeps the tensors once per touched dimension through the shared
// read-multiply-accumulate unit, then emits nt words, one per cycle at best.
// One item is worked on at a time.
// Reset (rst_n, synchronous, active low) clears control, positions and offsets.
`timescale 1ns / 1ps

module multi_tensor_strided_address_generator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  mtsag_in_if.sink                        in_chan,
  mtsag_out_if.source                     out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtsag_pkg::APB_AW-1:0]    paddr,
  input  logic [mtsag_pkg::APB_DW-1:0]    pwdata,
  output logic [mtsag_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  localparam int DIM_IW = mtsag_pkg::DIM_IW;
  localparam int TEN_IW = mtsag_pkg::TEN_IW;
  localparam int DCNT_W = mtsag_pkg::DCNT_W;
  localparam int TCNT_W = mtsag_pkg::TCNT_W;
  localparam int TAB_AW = mtsag_pkg::TAB_AW;
  localparam int VAL_W  = mtsag_pkg::VAL_W;
  localparam int EXT_W  = mtsag_pkg::EXT_W;
  localparam int CFG_W  = mtsag_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BS_MUL, ST_BS_WR, ST_OUTER_CHK, ST_SWEEP, ST_EMIT
  } state_t;

  // What follows a finished sweep.
  typedef enum logic [1:0] {
    CONT_OUTER, CONT_INNER, CONT_EMIT
  } cont_t;

  typedef struct packed {
    logic              go;
    logic [DIM_IW-1:0] dim;
    logic              use_bs;
    logic              sub;
    logic [VAL_W-1:0]  factor;
    cont_t             cont;
  } sweep_cmd_t;

  state_t             state_r;
  logic [CFG_W-1:0]   dim_count_r;
  logic [CFG_W-1:0]   tensor_count_r;
  logic [EXT_W-1:0]   ext_r  [mtsag_pkg::MAX_DIMS];
  logic [EXT_W-1:0]   pos_r  [mtsag_pkg::MAX_DIMS];
  logic [VAL_W-1:0]   offs_r [mtsag_pkg::MAX_TENSORS];

  logic [DIM_IW-1:0]  d_r;
  logic [DIM_IW-1:0]  sw_dim_r;
  logic               sw_bs_r;
  logic               sw_sub_r;
  logic [VAL_W-1:0]   factor_r;
  cont_t              cont_r;
  logic [TCNT_W-1:0]  iss_cnt_r;
  logic               v1_r, v2_r, v3_r;
  logic [TEN_IW-1:0]  t1_r, t2_r, t3_r;
  logic [VAL_W-1:0]   mul_a_r, mul_b_r, prod_r;
  logic [TAB_AW-1:0]  bs_addr_r;
  logic [TEN_IW-1:0]  e_r;

  logic               out_valid_r;
  logic [TEN_IW-1:0]  out_which_r;
  logic [VAL_W-1:0]   out_offset_r;
  logic               out_last_r;

  // Clamped counts and the innermost dimension.
  logic [CFG_W:0]     dim_ext, ten_ext;
  logic [DCNT_W-1:0]  nd;
  logic [TCNT_W-1:0]  nt;
  logic [DIM_IW-1:0]  inner_dim;
  logic [TEN_IW-1:0]  last_t;

  assign dim_ext = {1'b0, dim_count_r};
  assign ten_ext = {1'b0, tensor_count_r};
  assign nd = (dim_ext == '0) ? DCNT_W'(1) :
              (int'(dim_ext) > mtsag_pkg::MAX_DIMS) ? DCNT_W'(mtsag_pkg::MAX_DIMS) :
              DCNT_W'(dim_ext);
  assign nt = (ten_ext == '0) ? TCNT_W'(1) :
              (int'(ten_ext) > mtsag_pkg::MAX_TENSORS) ? TCNT_W'(mtsag_pkg::MAX_TENSORS) :
              TCNT_W'(ten_ext);
  assign inner_dim = DIM_IW'(nd - DCNT_W'(1));
  assign last_t    = TEN_IW'(nt - TCNT_W'(1));

  // Input handshake and index decode.
  logic              in_fire;
  logic              idx_ok_d, idx_ok_t;
  logic [DIM_IW-1:0] in_di;
  logic [TEN_IW-1:0] in_ti;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_di    = DIM_IW'(in_chan.dim_index);
  assign in_ti    = TEN_IW'(in_chan.tensor_index);
  assign idx_ok_d = int'(in_chan.dim_index) < mtsag_pkg::MAX_DIMS;
  assign idx_ok_t = int'(in_chan.tensor_index) < mtsag_pkg::MAX_TENSORS;

  // Single read port on the extent table and on the offset store.
  logic [DIM_IW-1:0] ext_idx;
  logic [EXT_W-1:0]  ext_rd;
  logic [TEN_IW-1:0] offs_idx;
  logic [VAL_W-1:0]  offs_rd;
  logic [EXT_W:0]    pos_inc;
  logic              pos_wrap;

  assign ext_idx  = (state_r == ST_IDLE) ? in_di : d_r;
  assign ext_rd   = ext_r[ext_idx];
  assign offs_idx = (state_r == ST_EMIT) ? e_r : t3_r;
  assign offs_rd  = offs_r[offs_idx];
  assign pos_inc  = {1'b0, pos_r[d_r]} + (EXT_W+1)'(1);
  assign pos_wrap = pos_inc >= {1'b0, ext_rd};

  // Sweep pipeline: issue read, capture operands, multiply, accumulate.
  logic              issue;
  logic              sweep_done;
  logic [TAB_AW-1:0] rd_addr;
  logic [VAL_W-1:0]  stride_rdata, bs_rdata;

  assign issue      = (state_r == ST_SWEEP) && (iss_cnt_r != nt);
  assign sweep_done = (state_r == ST_SWEEP) && (iss_cnt_r == nt) && !v1_r && !v2_r && !v3_r;
  assign rd_addr    = {TEN_IW'(iss_cnt_r), sw_dim_r};

  // Stride writes happen on a stride load; back-strides one multiply later.
  logic              stride_we;
  logic [TAB_AW-1:0] stride_waddr;

  assign stride_we    = in_fire && (in_chan.mode == mtsag_pkg::MODE_LOAD_STRIDE) &&
                        idx_ok_d && idx_ok_t;
  assign stride_waddr = {in_ti, in_di};

  mtsag_ram #(.WIDTH(VAL_W), .DEPTH(mtsag_pkg::TAB_DEPTH)) u_stride_ram (
    .clk   (clk),
    .we    (stride_we),
    .waddr (stride_waddr),
    .wdata ($unsigned(in_chan.load_value)),
    .raddr (rd_addr),
    .rdata (stride_rdata)
  );

  mtsag_ram #(.WIDTH(VAL_W), .DEPTH(mtsag_pkg::TAB_DEPTH)) u_bstride_ram (
    .clk   (clk),
    .we    (state_r == ST_BS_WR),
    .waddr (bs_addr_r),
    .wdata (prod_r),
    .raddr (rd_addr),
    .rdata (bs_rdata)
  );

  // Sweep requests from the sequencer.
  sweep_cmd_t sw_cmd;

  always_comb begin
    sw_cmd = '{go: 1'b0, dim: inner_dim, use_bs: 1'b1, sub: 1'b1,
               factor: VAL_W'(1), cont: CONT_EMIT};
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.mode)
            mtsag_pkg::MODE_NEXT_OUTER: begin
              sw_cmd.go = (nd < DCNT_W'(2));
            end
            mtsag_pkg::MODE_ADVANCE: begin
              sw_cmd.go     = 1'b1;
              sw_cmd.use_bs = 1'b0;
              sw_cmd.sub    = 1'b0;
              sw_cmd.factor = VAL_W'(in_chan.step_count);
            end
            mtsag_pkg::MODE_BACK_UP: begin
              sw_cmd.go     = 1'b1;
              sw_cmd.use_bs = 1'b0;
            end
            default: begin
              sw_cmd.go = 1'b0;
            end
          endcase
        end
      end
      ST_OUTER_CHK: begin
        sw_cmd.go  = 1'b1;
        sw_cmd.dim = d_r;
        if (pos_wrap) begin
          sw_cmd.cont = (d_r == '0) ? CONT_INNER : CONT_OUTER;
        end else begin
          sw_cmd.use_bs = 1'b0;
          sw_cmd.sub    = 1'b0;
          sw_cmd.cont   = CONT_INNER;
        end
      end
      ST_SWEEP: begin
        sw_cmd.go = sweep_done && (cont_r == CONT_INNER);
      end
      default: begin
        sw_cmd.go = 1'b0;
      end
    endcase
  end

  logic out_load;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  // Sequencer, shared unit and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      dim_count_r    <= CFG_W'(1);
      tensor_count_r <= CFG_W'(1);
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < mtsag_pkg::MAX_DIMS; i++) begin
        pos_r[i] <= '0;
      end
      for (int i = 0; i < mtsag_pkg::MAX_TENSORS; i++) begin
        offs_r[i] <= '0;
      end
    end else begin
      // Configuration writes.
      if (psel && penable && pwrite) begin
        if (paddr[2] == mtsag_pkg::REG_DIM_COUNT) begin
          dim_count_r <= pwdata[CFG_W-1:0];
        end else begin
          tensor_count_r <= pwdata[CFG_W-1:0];
        end
      end

      // The multiplier runs every cycle; its operands decide what it means.
      prod_r <= VAL_W'(mul_a_r * mul_b_r);

      // Pipeline stages of the sweep.
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (issue) begin
        t1_r      <= TEN_IW'(iss_cnt_r);
        iss_cnt_r <= iss_cnt_r + TCNT_W'(1);
      end
      t2_r <= t1_r;
      t3_r <= t2_r;
      if (v1_r) begin
        mul_a_r <= sw_bs_r ? bs_rdata : stride_rdata;
        mul_b_r <= factor_r;
      end
      if (v3_r) begin
        offs_r[t3_r] <= sw_sub_r ? (offs_rd - prod_r) : (offs_rd + prod_r);
      end

      // Output register.
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_which_r  <= e_r;
        out_offset_r <= offs_rd;
        out_last_r   <= (e_r == last_t);
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // Sweep start.
      if (sw_cmd.go) begin
        sw_dim_r  <= sw_cmd.dim;
        sw_bs_r   <= sw_cmd.use_bs;
        sw_sub_r  <= sw_cmd.sub;
        factor_r  <= sw_cmd.factor;
        cont_r    <= sw_cmd.cont;
        iss_cnt_r <= '0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_chan.mode)
              mtsag_pkg::MODE_LOAD_EXTENT: begin
                if (idx_ok_d) begin
                  ext_r[in_di] <= in_chan.load_value[EXT_W-1:0];
                end
              end
              mtsag_pkg::MODE_LOAD_STRIDE: begin
                if (idx_ok_d && idx_ok_t) begin
                  mul_a_r   <= VAL_W'(ext_rd) - VAL_W'(1);
                  mul_b_r   <= $unsigned(in_chan.load_value);
                  bs_addr_r <= stride_waddr;
                  state_r   <= ST_BS_MUL;
                end
              end
              mtsag_pkg::MODE_NEXT_OUTER: begin
                if (sw_cmd.go) begin
                  state_r <= ST_SWEEP;
                end else begin
                  d_r     <= DIM_IW'(nd - DCNT_W'(2));
                  state_r <= ST_OUTER_CHK;
                end
              end
              mtsag_pkg::MODE_ADVANCE, mtsag_pkg::MODE_BACK_UP: begin
                state_r <= ST_SWEEP;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_BS_MUL: begin
          state_r <= ST_BS_WR;
        end
        ST_BS_WR: begin
          state_r <= ST_IDLE;
        end
        ST_OUTER_CHK: begin
          pos_r[d_r] <= pos_wrap ? '0 : pos_inc[EXT_W-1:0];
          state_r    <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sweep_done) begin
            case (cont_r)
              CONT_OUTER: begin
                d_r     <= d_r - DIM_IW'(1);
                state_r <= ST_OUTER_CHK;
              end
              CONT_INNER: begin
                state_r <= ST_SWEEP;
              end
              default: begin
                e_r     <= '0;
                state_r <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (e_r == last_t) begin
              state_r <= ST_IDLE;
            end else begin
              e_r <= e_r + TEN_IW'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign out_chan.valid        = out_valid_r;
  assign out_chan.which_tensor = mtsag_pkg::IDX_W'(out_which_r);
  assign out_chan.offset       = $signed(out_offset_r);
  assign out_chan.last         = out_last_r;

  // Configuration reads.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mtsag_pkg::REG_DIM_COUNT) ?
                  mtsag_pkg::APB_DW'(dim_count_r) : mtsag_pkg::APB_DW'(tensor_count_r);

  // Sweep pipeline is only busy while sweeping.
  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r || v3_r) |-> (state_r == ST_SWEEP))
    else $error("sweep pipeline active outside a sweep");

  // The issue counter never passes the tensor count during a sweep.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (iss_cnt_r <= nt))
    else $error("sweep issued beyond the active tensors");

  // The last flag marks exactly the final active tensor.
  a_last_tensor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_which_r == last_t))
    else $error("last flag on a word that is not the final tensor");

  // A stride load with good indexes always goes on to compute its back-stride.
  a_bs_follows: assert property (@(posedge clk) disable iff (!rst_n)
    stride_we |=> (state_r == ST_BS_MUL) ##1 (state_r == ST_BS_WR))
    else $error("stride load did not write its back-stride");

endmodule
